### rtl/core/dts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, codes and a helper function of the depth-first topological sort core.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned VERTEX_W             = 6;
  localparam int unsigned COUNT_W              = 7;
  localparam int unsigned VERTEX_LIMIT         = 64;
  localparam int unsigned MAX_VERTEX_COUNT_DEF = 64;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_VERTEX_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // Operation codes
  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_SORT     = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] dest_vertex;
  } in_word_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last_of_order;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic add_rd;
    logic add_wr;
    logic clear_all;
    logic sort_init;
    logic root_next;
    logic root_enter;
    logic push;
    logic pop;
    logic pop_load;
    logic emit_init;
    logic emit_ld;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic edge_ok;
    logic root_done;
    logic root_visited;
    logic open_any;
    logic depth_one;
    logic emit_last;
    logic out_free;
  } stat_t;

  // Index of the lowest set bit; top index when none is set
  function automatic logic [VERTEX_W-1:0] lowest_set(input logic [VERTEX_LIMIT-1:0] m);
    logic [VERTEX_W-1:0] idx;
    idx = VERTEX_W'(VERTEX_LIMIT - 1);
    for (int i = VERTEX_LIMIT - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = VERTEX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

### rtl/core/dts_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dts_stream_if
// Valid/ready word channel with a typed payload.
// ----------------------------------------------------------------------------
interface dts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/dts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dts_ctrl
// Sequencer of the sort core: decodes words, walks the search, emits results.
// ----------------------------------------------------------------------------
module dts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      operation_i,
  output logic                 in_ready_o,
  input  wire dts_pkg::stat_t  stat_i,
  output dts_pkg::cmd_t        cmd_o
);
  import dts_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ADD_WR  = 3'd1;
  localparam logic [2:0] ST_ROOT    = 3'd2;
  localparam logic [2:0] ST_EVAL    = 3'd3;
  localparam logic [2:0] ST_POP     = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_LD = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (operation_i)
            OP_ADD_EDGE: begin
              if (stat_i.edge_ok) begin
                cmd_o.add_rd = 1'b1;
                state_d      = ST_ADD_WR;
              end
            end
            OP_SORT: begin
              if (!stat_i.n_zero) begin
                cmd_o.sort_init = 1'b1;
                state_d         = ST_ROOT;
              end
            end
            OP_CLEAR: cmd_o.clear_all = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_ROOT: begin
        priority if (stat_i.root_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_EMIT_RD;
        end else if (stat_i.root_visited) begin
          cmd_o.root_next = 1'b1;
        end else begin
          cmd_o.root_enter = 1'b1;
          state_d          = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.open_any) begin
          cmd_o.push = 1'b1;
        end else begin
          cmd_o.pop = 1'b1;
          if (stat_i.depth_one) begin
            cmd_o.root_next = 1'b1;
            state_d         = ST_ROOT;
          end else begin
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_EVAL;
      end
      ST_EMIT_RD: begin
        if (stat_i.out_free) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = stat_i.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dts_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dts_dp
// Datapath: adjacency memory, path stack, finish list, marks and result word.
// ----------------------------------------------------------------------------
module dts_dp #(
  parameter int unsigned MAX_VERTEX_COUNT = dts_pkg::MAX_VERTEX_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dts_pkg::cmd_t               cmd_i,
  output dts_pkg::stat_t                   stat_o,
  input  wire dts_pkg::in_word_t           in_word_i,
  input  wire logic [dts_pkg::COUNT_W-1:0] vertex_count_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output dts_pkg::out_word_t               out_word_o
);
  import dts_pkg::*;

  localparam int unsigned MAXV = MAX_VERTEX_COUNT;
  localparam int unsigned AW   = $clog2(MAXV);
  localparam int unsigned CW   = $clog2(MAXV + 1);

  // Memories
  logic [MAXV-1:0] adj_mem   [MAXV];
  logic [AW-1:0]   stack_mem [MAXV];
  logic [AW-1:0]   fin_mem   [MAXV];

  logic [MAXV-1:0] adj_rd_q;
  logic [AW-1:0]   stack_rd_q;
  logic [AW-1:0]   fin_rd_q;

  // Control state
  logic [MAXV-1:0] row_vld_q, visited_q, use_q;
  logic            row_vld_rd_q;
  logic [CW-1:0]   n_q, root_q, depth_q, fin_cnt_q;
  logic [AW-1:0]   emit_q;
  logic            out_valid_q;

  // Payload registers
  logic [AW-1:0]   top_q, src_q, dst_q;
  out_word_t       out_word_q;

  // Combinational
  logic [CW-1:0]   n_sat, depth_m2;
  logic [MAXV-1:0] use_d, row, open, add_row;
  logic [AW-1:0]   next, adj_addr, root_idx, stack_wa, stack_wd;
  logic            stack_we;

  assign n_sat = (vertex_count_i > COUNT_W'(MAXV)) ? CW'(MAXV) : CW'(vertex_count_i);

  always_comb begin
    for (int i = 0; i < MAXV; i++) begin
      use_d[i] = (CW'(i) < n_sat);
    end
  end

  assign root_idx = root_q[AW-1:0];
  assign depth_m2 = depth_q - CW'(2);
  assign row      = row_vld_rd_q ? adj_rd_q : '0;
  assign open     = row & ~visited_q & use_q;
  assign next     = AW'(lowest_set(VERTEX_LIMIT'(open)));
  assign add_row  = row | (MAXV'(1) << dst_q);

  // One read port on the adjacency memory
  always_comb begin
    priority if (cmd_i.add_rd) begin
      adj_addr = in_word_i.source_vertex[AW-1:0];
    end else if (cmd_i.root_enter) begin
      adj_addr = root_idx;
    end else if (cmd_i.push) begin
      adj_addr = next;
    end else begin
      adj_addr = stack_rd_q;
    end
  end

  assign stack_we = cmd_i.root_enter | cmd_i.push;
  assign stack_wa = cmd_i.root_enter ? '0 : depth_q[AW-1:0];
  assign stack_wd = cmd_i.root_enter ? root_idx : next;

  always_ff @(posedge clk_i) begin
    adj_rd_q   <= adj_mem[adj_addr];
    stack_rd_q <= stack_mem[depth_m2[AW-1:0]];
    fin_rd_q   <= fin_mem[emit_q];
    if (cmd_i.add_wr) begin
      adj_mem[src_q] <= add_row;
    end
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (cmd_i.pop) begin
      fin_mem[fin_cnt_q[AW-1:0]] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_rd) begin
      src_q <= in_word_i.source_vertex[AW-1:0];
      dst_q <= in_word_i.dest_vertex[AW-1:0];
    end
    priority if (cmd_i.root_enter) begin
      top_q <= root_idx;
    end else if (cmd_i.push) begin
      top_q <= next;
    end else if (cmd_i.pop_load) begin
      top_q <= stack_rd_q;
    end
    if (cmd_i.emit_ld) begin
      out_word_q.vertex        <= VERTEX_W'(fin_rd_q);
      out_word_q.last_of_order <= (emit_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      row_vld_rd_q <= 1'b0;
      visited_q    <= '0;
      use_q        <= '0;
      n_q          <= '0;
      root_q       <= '0;
      depth_q      <= '0;
      fin_cnt_q    <= '0;
      emit_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      row_vld_rd_q <= row_vld_q[adj_addr];
      if (cmd_i.clear_all) begin
        row_vld_q <= '0;
      end else if (cmd_i.add_wr) begin
        row_vld_q <= row_vld_q | (MAXV'(1) << src_q);
      end
      if (cmd_i.sort_init) begin
        visited_q <= '0;
        use_q     <= use_d;
        n_q       <= n_sat;
        root_q    <= '0;
        fin_cnt_q <= '0;
      end
      if (cmd_i.root_enter) begin
        visited_q <= visited_q | (MAXV'(1) << root_idx);
        depth_q   <= CW'(1);
      end
      if (cmd_i.push) begin
        visited_q <= visited_q | (MAXV'(1) << next);
        depth_q   <= depth_q + CW'(1);
      end
      if (cmd_i.pop) begin
        depth_q   <= depth_q - CW'(1);
        fin_cnt_q <= fin_cnt_q + CW'(1);
      end
      if (cmd_i.root_next) begin
        root_q <= root_q + CW'(1);
      end
      if (cmd_i.emit_init) begin
        emit_q <= AW'(fin_cnt_q - CW'(1));
      end else if (cmd_i.emit_ld) begin
        emit_q <= emit_q - AW'(1);
      end
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.n_zero       = (vertex_count_i == '0);
  assign stat_o.edge_ok      = (COUNT_W'(in_word_i.source_vertex) < COUNT_W'(MAXV)) &&
                               (COUNT_W'(in_word_i.dest_vertex) < COUNT_W'(MAXV));
  assign stat_o.root_done    = (root_q == n_q);
  assign stat_o.root_visited = visited_q[root_idx];
  assign stat_o.open_any     = |open;
  assign stat_o.depth_one    = (depth_q == CW'(1));
  assign stat_o.emit_last    = (emit_q == '0);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

### rtl/core/dfs_topological_sort_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_topological_sort_core
// Topological sort of a directed graph by depth-first search.
// ----------------------------------------------------------------------------
// The graph lives in an adjacency bit matrix, one row per source vertex, in a
// memory with a single read port whose rows carry valid flops so that a
// clear-all-edges word completes as soon as it is taken and reset empties
// the graph at once. An input word either adds an edge, clears all edges or
// sorts. A sort scans roots in ascending order, and for every vertex entered
// it pushes it onto the path, later finds it exhausted and pops it, and
// reloads the new top of the path from the stack memory unless the path is
// then empty; the pace is set by the single adjacency read port and its
// registered read data. Each result word is then read from the finish-list
// memory and loaded into the output register once that register is free.
// Only one input word is in work at a time; the last result may still wait
// in the output register while the next input word is taken. vertex_count
// is written through the APB port at offset 0 and saturates at
// MAX_VERTEX_COUNT; zero makes a sort produce no words.
// ----------------------------------------------------------------------------
module dfs_topological_sort_core #(
  parameter int unsigned MAX_VERTEX_COUNT = dts_pkg::MAX_VERTEX_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dts_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dts_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [dts_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  // Word channels
  dts_stream_if.sink                          in_i,
  dts_stream_if.source                        out_o
);
  import dts_pkg::*;

  logic [COUNT_W-1:0] vertex_count_q;
  logic               reg_hit;
  cmd_t               cmd;
  stat_t              stat;
  in_word_t           in_word;
  out_word_t          out_word;
  logic               out_valid;
  logic               in_ready;

  // Register decode: the word index sits above the byte offset
  assign reg_hit = (paddr[APB_ADDR_W-1] == REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign in_word     = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_word;

  // Sequencer: decode, search walk, result emission
  dts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_word.operation),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Graph storage, search state and output register
  dts_dp #(
    .MAX_VERTEX_COUNT (MAX_VERTEX_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_word_i      (in_word),
    .vertex_count_i (vertex_count_q),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .out_word_o     (out_word)
  );

endmodule
`default_nettype wire

### rtl/core/dts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dts_assertions
// Port-level checks of the sort core, bound to the top level.
// ----------------------------------------------------------------------------
module dts_assertions (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [5:0] out_vertex_i,
  input wire logic       out_last_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_vertex_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // Drop ready only after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready dropped without an accepted word");

  // A new result appears only while a sort is in work
  a_out_from_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result word raised while idle");

  // Stay busy until the flagged last word
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)
    else $error("input taken before the order was complete");

endmodule

bind dfs_topological_sort_core dts_assertions u_dts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_vertex_i (out_o.data.vertex),
  .out_last_i   (out_o.data.last_of_order)
);
`default_nettype wire
